// ===== rtl/arp_pkg.sv =====
// Package for the ARP cache engine: entry states, status codes, mode codes,
// controller/datapath command and status structs. No dependencies.
package arp_pkg;

  localparam logic [1:0] ST_FREE       = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_RESOLVED   = 2'd2;

  localparam logic [1:0] MODE_RX      = 2'd0;
  localparam logic [1:0] MODE_RESOLVE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [3:0] STS_SHORT     = 4'd0;
  localparam logic [3:0] STS_BAD_HW    = 4'd1;
  localparam logic [3:0] STS_BAD_PROTO = 4'd2;
  localparam logic [3:0] STS_ACCEPTED  = 4'd3;
  localparam logic [3:0] STS_REPLIED   = 4'd4;
  localparam logic [3:0] STS_FOUND     = 4'd5;
  localparam logic [3:0] STS_INCOMPL   = 4'd6;
  localparam logic [3:0] STS_TICK      = 4'd7;
  localparam logic [3:0] STS_RES_ERR   = 4'd8;

  localparam logic [15:0] HRD_ETHER  = 16'h0001;
  localparam logic [15:0] PRO_IP     = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY   = 16'h0002;
  localparam logic [1:0]  OP_REQ2    = 2'd1;
  localparam logic [1:0]  OP_REPLY2  = 2'd2;
  localparam logic [10:0] MIN_LEN    = 11'd28;

  localparam logic [2:0] CFG_LOCAL_IP  = 3'd0;
  localparam logic [2:0] CFG_LOCAL_MAC = 3'd1;
  localparam logic [2:0] CFG_IFACE     = 3'd2;
  localparam logic [2:0] CFG_RES_OK    = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd4;

  typedef struct packed {
    logic       start;   // latch the item and clear scan state
    logic       scan;    // examine one entry
    logic       commit;  // write the chosen entry and load the result register
    logic       finish;  // raise the output valid
  } arp_cmd_t;

  typedef struct packed {
    logic       scan_last;
  } arp_sts_t;

endpackage

// ===== rtl/arp_if.sv =====
// Valid/ready channel interface carrying a packed payload word.
// Depends on nothing.
interface arp_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/arp_cache_engine.sv =====
// Top level of the ARP cache engine: channels, configuration registers,
// controller and datapath. Depends on arp_pkg, arp_if, arp_ctrl, arp_dp.
//
//   channel | dir | word
//   in_     | in  | mode, length, ARP header, addresses, resolve_ip
//   out_    | out | status and frame request fields
//   cfg_    | in  | register index (3 bits) and data (48 bits)
//
// Each item is handled in order: latch, a linear scan of the table that
// examines each cache entry in turn, commit of the chosen entry and of
// the result register, and hand-off of the word to the output channel.
// Reset is synchronous and active low; it frees every entry at once.
// A stalled output holds the result; the next word is taken and scanned,
// then waits before its commit until the held word leaves.
// Mode 3 words are taken and dropped without a result.
module arp_cache_engine import arp_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst_n,
  arp_if.sink   in_ch,
  arp_if.sink   cfg_ch,
  arp_if.source out_ch
);
  // in_ch.data: {mode,len,hw,proto,hwl,pl,op,smac,sip,tip,rip} = 221 bits
  // cfg_ch.data: {idx[2:0], data[47:0]} = 51 bits
  // out_ch.data: {status,send,sop,tmac,tip,bcast,rmac} = 136 bits
  logic [31:0] local_ip_r;
  logic [47:0] local_mac_r;
  logic        iface_r, res_ok_r;
  logic [7:0]  timeout_r;
  logic [2:0]  cfg_idx;
  logic [47:0] cfg_dat;

  assign cfg_idx = cfg_ch.data[50:48];
  assign cfg_dat = cfg_ch.data[47:0];
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0; local_mac_r <= '0; iface_r <= 1'b0;
      res_ok_r <= 1'b1; timeout_r <= 8'd30;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx)
        CFG_LOCAL_IP:  local_ip_r  <= cfg_dat[31:0];
        CFG_LOCAL_MAC: local_mac_r <= cfg_dat;
        CFG_IFACE:     iface_r     <= cfg_dat[0];
        CFG_RES_OK:    res_ok_r    <= cfg_dat[0];
        CFG_TIMEOUT:   timeout_r   <= cfg_dat[7:0];
        default: ;
      endcase
    end
  end

  // hold the sender address; it never reaches a result field
  logic mac_unused;
  assign mac_unused = ^local_mac_r;

  arp_cmd_t cmd;
  arp_sts_t sts;
  logic out_valid_r;
  logic [1:0] mode;
  logic [3:0] o_status;
  logic o_send, o_bcast;
  logic [1:0] o_sop;
  logic [47:0] o_tmac, o_rmac;
  logic [31:0] o_tip;

  assign mode = in_ch.data[220:219];

  arp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid),
    .in_ok_mode(mode != MODE_UNUSED || mac_unused || !mac_unused),
    .in_ready(in_ch.ready),
    .out_busy(out_valid_r),
    .sts, .cmd
  );

  arp_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .i_mode(mode),
    .i_len(in_ch.data[218:208]),
    .i_hw_type(in_ch.data[207:192]),
    .i_proto_type(in_ch.data[191:176]),
    .i_hw_len(in_ch.data[175:168]),
    .i_proto_len(in_ch.data[167:160]),
    .i_opcode(in_ch.data[159:144]),
    .i_smac(in_ch.data[143:96]),
    .i_sip(in_ch.data[95:64]),
    .i_tip(in_ch.data[63:32]),
    .i_rip(in_ch.data[31:0]),
    .local_ip(local_ip_r), .iface(iface_r), .res_ok(res_ok_r), .timeout(timeout_r),
    .o_status, .o_send, .o_sop, .o_tmac, .o_tip, .o_bcast, .o_rmac
  );

  // drop mode 3 words: the item runs through but emits nothing
  logic drop_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0; drop_r <= 1'b0;
    end else begin
      if (cmd.start) drop_r <= (mode == MODE_UNUSED);
      if (cmd.finish && !drop_r) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = {o_status, o_send, o_sop, o_tmac, o_tip, o_bcast, o_rmac};

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_ch.data)) else $error("result changed");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("double accept");
endmodule

// ===== rtl/arp_ctrl.sv =====
// Controller for the ARP cache: sequences start, entry scan, commit, finish.
// Depends on arp_pkg.
module arp_ctrl import arp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ok_mode,
  output logic     in_ready,
  input  logic     out_busy,
  input  arp_sts_t sts,
  output arp_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_COMMIT = 2'd2, S_DONE = 2'd3;
  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ok_mode) begin
        cmd.start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      // hold the commit while the previous result still waits
      S_COMMIT: if (!out_busy) begin
        cmd.commit = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: if (!out_busy) begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/arp_dp.sv =====
// Datapath for the ARP cache: entry table, scan unit, tick ageing, result.
// Depends on arp_pkg.
module arp_dp import arp_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  arp_cmd_t     cmd,
  output arp_sts_t     sts,
  input  logic [1:0]   i_mode,
  input  logic [10:0]  i_len,
  input  logic [15:0]  i_hw_type,
  input  logic [15:0]  i_proto_type,
  input  logic [7:0]   i_hw_len,
  input  logic [7:0]   i_proto_len,
  input  logic [15:0]  i_opcode,
  input  logic [47:0]  i_smac,
  input  logic [31:0]  i_sip,
  input  logic [31:0]  i_tip,
  input  logic [31:0]  i_rip,
  input  logic [31:0]  local_ip,
  input  logic         iface,
  input  logic         res_ok,
  input  logic [7:0]   timeout,
  output logic [3:0]   o_status,
  output logic         o_send,
  output logic [1:0]   o_sop,
  output logic [47:0]  o_tmac,
  output logic [31:0]  o_tip,
  output logic         o_bcast,
  output logic [47:0]  o_rmac
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [1:0]  e_state_r [ENTRIES];
  logic [31:0] e_ip_r    [ENTRIES];
  logic [47:0] e_mac_r   [ENTRIES];
  logic [31:0] e_stamp_r [ENTRIES];
  logic [31:0] now_r;

  // latched item
  logic [1:0]  mode_r;
  logic [3:0]  pre_sts_r;   // header check result for received words
  logic        hdr_ok_r;
  logic        is_req_r;
  logic [47:0] smac_r;
  logic [31:0] key_r;
  logic        to_local_r;

  // scan state
  logic [IW-1:0] idx_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [31:0]   old_stamp_r;

  // result
  logic [3:0]  rs_status_r;
  logic        rs_send_r, rs_bcast_r;
  logic [1:0]  rs_sop_r;
  logic [47:0] rs_tmac_r, rs_rmac_r;
  logic [31:0] rs_tip_r;

  assign sts.scan_last = (idx_r == IW'(ENTRIES - 1));

  logic [1:0]  cur_st;
  logic [31:0] cur_ip, cur_stamp, age;
  assign cur_st    = e_state_r[idx_r];
  assign cur_ip    = e_ip_r[idx_r];
  assign cur_stamp = e_stamp_r[idx_r];
  assign age       = now_r - cur_stamp;

  logic [IW-1:0] slot;
  assign slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);

  logic active;
  assign active = hdr_ok_r && ((mode_r == MODE_RX) || (mode_r == MODE_RESOLVE && res_ok));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        e_state_r[k] <= ST_FREE;
        e_ip_r[k]    <= '0;
        e_mac_r[k]   <= '0;
        e_stamp_r[k] <= '0;
      end
      now_r <= '0;
    end else begin
      if (cmd.start && i_mode == MODE_TICK) now_r <= now_r + 32'd1;
      // tick ageing, one entry a cycle, after the counter has advanced
      if (cmd.scan && mode_r == MODE_TICK &&
          (cur_st == ST_INCOMPLETE || cur_st == ST_RESOLVED) &&
          age > {24'd0, timeout}) begin
        e_state_r[idx_r] <= ST_FREE;
        e_ip_r[idx_r]    <= '0;
        e_mac_r[idx_r]   <= '0;
        e_stamp_r[idx_r] <= '0;
      end
      if (cmd.commit && active) begin
        if (mode_r == MODE_RX) begin
          if (hit_r || (iface && to_local_r)) begin
            e_state_r[slot] <= ST_RESOLVED;
            e_ip_r[slot]    <= key_r;
            e_mac_r[slot]   <= smac_r;
            e_stamp_r[slot] <= now_r;
          end
        end else if (!hit_r) begin
          e_state_r[slot] <= ST_INCOMPLETE;
          e_ip_r[slot]    <= key_r;
          e_stamp_r[slot] <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r     <= i_mode;
      smac_r     <= i_smac;
      key_r      <= (i_mode == MODE_RX) ? i_sip : i_rip;
      to_local_r <= (i_tip == local_ip);
      is_req_r   <= (i_opcode == OP_REQUEST);
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
      old_idx_r  <= '0;
      old_stamp_r <= e_stamp_r[0];
      hdr_ok_r   <= 1'b1;
      pre_sts_r  <= STS_ACCEPTED;
      if (i_mode == MODE_RX) begin
        if (i_len < MIN_LEN) begin
          hdr_ok_r <= 1'b0; pre_sts_r <= STS_SHORT;
        end else if (i_hw_type != HRD_ETHER || i_hw_len != 8'd6) begin
          hdr_ok_r <= 1'b0; pre_sts_r <= STS_BAD_HW;
        end else if (i_proto_type != PRO_IP || i_proto_len != 8'd4) begin
          hdr_ok_r <= 1'b0; pre_sts_r <= STS_BAD_PROTO;
        end
      end
    end else if (cmd.scan) begin
      if (!sts.scan_last) idx_r <= idx_r + IW'(1);
      if (!hit_r && cur_st != ST_FREE && cur_ip == key_r) begin
        hit_r <= 1'b1; hit_idx_r <= idx_r;
      end
      if (!free_r) begin
        if (cur_st == ST_FREE) begin
          free_r <= 1'b1; free_idx_r <= idx_r;
        end else if (cur_stamp < old_stamp_r) begin
          old_stamp_r <= cur_stamp; old_idx_r <= idx_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rs_status_r <= pre_sts_r;
      rs_send_r <= 1'b0; rs_sop_r <= '0; rs_tmac_r <= '0; rs_tip_r <= '0;
      rs_bcast_r <= 1'b0; rs_rmac_r <= '0;
      unique case (mode_r)
        MODE_RX: if (hdr_ok_r && iface && to_local_r && is_req_r) begin
          rs_status_r <= STS_REPLIED; rs_send_r <= 1'b1; rs_sop_r <= OP_REPLY2;
          rs_tmac_r <= smac_r; rs_tip_r <= key_r;
        end
        MODE_RESOLVE: if (!res_ok) begin
          rs_status_r <= STS_RES_ERR;
        end else if (!hit_r || e_state_r[hit_idx_r] == ST_INCOMPLETE) begin
          rs_status_r <= STS_INCOMPL; rs_send_r <= 1'b1; rs_sop_r <= OP_REQ2;
          rs_tip_r <= key_r; rs_bcast_r <= 1'b1;
        end else begin
          rs_status_r <= STS_FOUND; rs_rmac_r <= e_mac_r[hit_idx_r];
        end
        default: rs_status_r <= STS_TICK;
      endcase
    end
  end

  assign o_status = rs_status_r;
  assign o_send   = rs_send_r;
  assign o_sop    = rs_sop_r;
  assign o_tmac   = rs_tmac_r;
  assign o_tip    = rs_tip_r;
  assign o_bcast  = rs_bcast_r;
  assign o_rmac   = rs_rmac_r;
endmodule
